// ===== rtl/core/hlg_pkg.sv =====
// shared types and constants for the hysteretic level gate
package hlg_pkg;

  localparam int DEFAULT_BOUNDARY_COUNT = 6;
  localparam int DEFAULT_RAW_BITS       = 12;

  localparam int MAX_BOUNDARIES = 6;
  localparam int SLICE_BITS     = 12;
  localparam int SLICES_PER_REG = 3;
  localparam int CFG_DATA_BITS  = SLICE_BITS * SLICES_PER_REG;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LEVEL_BITS     = 3;
  localparam int COUNT_BITS     = 16;
  localparam int HALF_BITS      = SLICE_BITS - 1;

  localparam logic [LEVEL_BITS-1:0] NEUTRAL_LEVEL = 3'd3;
  localparam logic [LEVEL_BITS-1:0] DRY_LEVEL     = 3'd0;
  localparam logic [LEVEL_BITS-1:0] WET_LEVEL     = 3'd6;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BOUNDARIES_LOW  = 3'd0,
    REG_BOUNDARIES_HIGH = 3'd1,
    REG_DEADBAND_WIDTH  = 3'd2,
    REG_SENSOR_RESIST   = 3'd3,
    REG_CONFIRM_DRY     = 3'd4,
    REG_CONFIRM_SOIL    = 3'd5,
    REG_CONFIRM_WET     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] boundaries_low;
    logic [CFG_DATA_BITS-1:0] boundaries_high;
    logic [SLICE_BITS-1:0]    deadband_width;
    logic                     resistive_mode;
    logic [COUNT_BITS-1:0]    confirm_dry;
    logic [COUNT_BITS-1:0]    confirm_soil;
    logic [COUNT_BITS-1:0]    confirm_wet;
  } cfg_t;

endpackage

// ===== rtl/core/hlg_classify.sv =====
// level classifier: counts crossed boundaries shifted by the half deadband
module hlg_classify #(
  parameter int BOUNDARY_COUNT = hlg_pkg::DEFAULT_BOUNDARY_COUNT,
  parameter int RAW_BITS       = hlg_pkg::DEFAULT_RAW_BITS
) (
  input  logic [RAW_BITS-1:0]             raw,
  input  logic [hlg_pkg::LEVEL_BITS-1:0]  ref_level,
  input  logic [hlg_pkg::HALF_BITS-1:0]   half,
  input  hlg_pkg::cfg_t                   cfg,
  output logic [hlg_pkg::LEVEL_BITS-1:0]  band
);
  import hlg_pkg::*;

  localparam int CMP_W = (RAW_BITS > SLICE_BITS) ? RAW_BITS + 2 : SLICE_BITS + 2;

  logic [2*CFG_DATA_BITS-1:0] all_bounds;
  logic signed [CMP_W-1:0]    raw_s;
  logic signed [CMP_W-1:0]    half_s;
  logic [BOUNDARY_COUNT-1:0]  crossed;

  assign all_bounds = {cfg.boundaries_high, cfg.boundaries_low};
  assign raw_s      = CMP_W'(raw);
  assign half_s     = CMP_W'(half);

  for (genvar i = 0; i < BOUNDARY_COUNT; i++) begin : g_bound
    logic signed [CMP_W-1:0] b_s;
    logic signed [CMP_W-1:0] eff;
    logic                    below;

    assign b_s   = CMP_W'(all_bounds[i*SLICE_BITS +: SLICE_BITS]);
    assign below = ref_level > LEVEL_BITS'(i);

    assign eff = cfg.resistive_mode ? (below ? (b_s - half_s) : (b_s + half_s))
                                    : (below ? (b_s + half_s) : (b_s - half_s));
    assign crossed[i] = cfg.resistive_mode ? (raw_s > eff) : (raw_s < eff);
  end

  always_comb begin
    band = '0;
    for (int i = 0; i < BOUNDARY_COUNT; i++) begin
      band = band + LEVEL_BITS'(crossed[i]);
    end
  end

endmodule

// ===== rtl/core/hlg_track.sv =====
// committed and pending level with confirmation run counter
module hlg_track (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            seed,
  input  logic [hlg_pkg::LEVEL_BITS-1:0]  cand,
  input  hlg_pkg::cfg_t                   cfg,
  output logic [hlg_pkg::LEVEL_BITS-1:0]  committed,
  output logic [hlg_pkg::LEVEL_BITS-1:0]  committed_next
);
  import hlg_pkg::*;

  logic [LEVEL_BITS-1:0] pending;
  logic [LEVEL_BITS-1:0] pending_next;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] run_raw;
  logic [COUNT_BITS-1:0] run_len;

  always_comb begin
    if (cand == DRY_LEVEL) begin
      run_raw = cfg.confirm_dry;
    end else if (cand >= WET_LEVEL) begin
      run_raw = cfg.confirm_wet;
    end else begin
      run_raw = cfg.confirm_soil;
    end
  end

  assign run_len   = (run_raw == '0) ? COUNT_BITS'(1) : run_raw;
  assign count_inc = count + COUNT_BITS'(1);

  always_comb begin
    committed_next = committed;
    pending_next   = pending;
    count_next     = count;
    if (seed) begin
      committed_next = cand;
      pending_next   = cand;
      count_next     = '0;
    end else if (cand == committed) begin
      pending_next = cand;
      count_next   = '0;
    end else if (cand == pending) begin
      if (count_inc >= run_len) begin
        committed_next = cand;
        pending_next   = cand;
        count_next     = '0;
      end else begin
        count_next = count_inc;
      end
    end else begin
      pending_next = cand;
      count_next   = COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= NEUTRAL_LEVEL;
      pending   <= NEUTRAL_LEVEL;
      count     <= '0;
    end else if (step) begin
      committed <= committed_next;
      pending   <= pending_next;
      count     <= count_next;
    end
  end

endmodule

// ===== rtl/core/hysteretic_level_gate_core.sv =====
// top level of the hysteretic level gate: config registers and pipeline
//
//  channel | signals                            | role
//  in      | in_valid in_ready func raw_value   | sample or seed in
//  out     | out_valid out_ready level          | committed level per sample
//  cfg     | cfg_write cfg_index cfg_data       | register write, no wait
//
// one transfer per cycle in each direction while the result is not stalled;
// an input transfer passes through the input register, then the result register
// the whole classify and confirm update sits between those two registers
// reset clears the level state to the neutral level and loads config defaults
// a stalled result holds; the input register still drains into a free result
module hysteretic_level_gate_core #(
  parameter int BOUNDARY_COUNT = hlg_pkg::DEFAULT_BOUNDARY_COUNT,
  parameter int RAW_BITS       = hlg_pkg::DEFAULT_RAW_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  logic [RAW_BITS-1:0]                raw_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hlg_pkg::LEVEL_BITS-1:0]     level,
  input  logic                               cfg_write,
  input  logic [hlg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hlg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import hlg_pkg::*;

  cfg_t                  cfg;
  logic                  s1_valid;
  logic                  s1_func;
  logic [RAW_BITS-1:0]   s1_raw;
  logic                  advance;
  logic [LEVEL_BITS-1:0] committed;
  logic [LEVEL_BITS-1:0] committed_next;
  logic [LEVEL_BITS-1:0] ref_level;
  logic [HALF_BITS-1:0]  half;
  logic [LEVEL_BITS-1:0] cand;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boundaries_low   <= '0;
      cfg.boundaries_high  <= '0;
      cfg.deadband_width   <= '0;
      cfg.resistive_mode   <= 1'b0;
      cfg.confirm_dry      <= COUNT_BITS'(1);
      cfg.confirm_soil     <= COUNT_BITS'(1);
      cfg.confirm_wet      <= COUNT_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOUNDARIES_LOW:  cfg.boundaries_low   <= cfg_data;
        REG_BOUNDARIES_HIGH: cfg.boundaries_high  <= cfg_data;
        REG_DEADBAND_WIDTH:  cfg.deadband_width   <= cfg_data[SLICE_BITS-1:0];
        REG_SENSOR_RESIST:   cfg.resistive_mode   <= cfg_data[0];
        REG_CONFIRM_DRY:     cfg.confirm_dry      <= cfg_data[COUNT_BITS-1:0];
        REG_CONFIRM_SOIL:    cfg.confirm_soil     <= cfg_data[COUNT_BITS-1:0];
        REG_CONFIRM_WET:     cfg.confirm_wet      <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func <= func;
      s1_raw  <= raw_value;
    end
  end

  // seed classifies against the neutral level with no deadband
  assign ref_level = s1_func ? NEUTRAL_LEVEL : committed;
  assign half      = s1_func ? '0 : cfg.deadband_width[SLICE_BITS-1:1];

  hlg_classify #(
    .BOUNDARY_COUNT(BOUNDARY_COUNT),
    .RAW_BITS(RAW_BITS)
  ) u_classify (
    .raw(s1_raw),
    .ref_level(ref_level),
    .half(half),
    .cfg(cfg),
    .band(cand)
  );

  hlg_track u_track (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .seed(s1_func),
    .cand(cand),
    .cfg(cfg),
    .committed(committed),
    .committed_next(committed_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level <= committed_next;
    end
  end

endmodule

// ===== verif/hysteretic_level_gate_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the hysteretic level gate core with a level-tracking scoreboard
module hysteretic_level_gate_core_test;
  import hlg_pkg::*;

  localparam bit FUNC_UPDATE = 1'b0;
  localparam bit FUNC_SEED   = 1'b1;
  localparam int RAW_MAX     = (1 << DEFAULT_RAW_BITS) - 1;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic                        func;
  logic [DEFAULT_RAW_BITS-1:0] raw_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [LEVEL_BITS-1:0]       level;
  logic                        cfg_write;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_data;

  bit calm;
  int settings;

  class level_tracker;
    logic [CFG_DATA_BITS-1:0] bnd_lo, bnd_hi;
    logic [SLICE_BITS-1:0]    deadband;
    bit                       resistive;
    logic [COUNT_BITS-1:0]    run_dry, run_soil, run_wet;
    logic [LEVEL_BITS-1:0]    committed, pending_lvl;
    logic [COUNT_BITS-1:0]    run_count;
    logic [LEVEL_BITS-1:0]    expected_levels[$];
    int errors, samples, seeds, changes;

    function new();
      bnd_lo = '0;
      bnd_hi = '0;
      deadband = '0;
      resistive = 1'b0;
      run_dry = 16'd1;
      run_soil = 16'd1;
      run_wet = 16'd1;
      committed = NEUTRAL_LEVEL;
      pending_lvl = NEUTRAL_LEVEL;
      run_count = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        REG_BOUNDARIES_LOW:  bnd_lo = d;
        REG_BOUNDARIES_HIGH: bnd_hi = d;
        REG_DEADBAND_WIDTH:  deadband = d[SLICE_BITS-1:0];
        REG_SENSOR_RESIST:   resistive = d[0];
        REG_CONFIRM_DRY:     run_dry = d[COUNT_BITS-1:0];
        REG_CONFIRM_SOIL:    run_soil = d[COUNT_BITS-1:0];
        REG_CONFIRM_WET:     run_wet = d[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int boundary(int i);
      if (i < SLICES_PER_REG)
        return int'(bnd_lo[i*SLICE_BITS +: SLICE_BITS]);
      return int'(bnd_hi[(i-SLICES_PER_REG)*SLICE_BITS +: SLICE_BITS]);
    endfunction

    // count crossed boundaries, each pushed half the deadband away from the reference level
    function logic [LEVEL_BITS-1:0] classify(logic [DEFAULT_RAW_BITS-1:0] raw,
                                             logic [LEVEL_BITS-1:0] ref_lvl,
                                             logic [SLICE_BITS-1:0] db);
      int half, r, eff, i;
      logic [LEVEL_BITS-1:0] band;
      half = int'(db >> 1);
      r = int'(raw);
      band = '0;
      for (i = 0; i < DEFAULT_BOUNDARY_COUNT; i++) begin
        if (resistive) begin
          eff = (i < int'(ref_lvl)) ? boundary(i) - half : boundary(i) + half;
          if (r > eff) band++;
        end else begin
          eff = (i < int'(ref_lvl)) ? boundary(i) + half : boundary(i) - half;
          if (r < eff) band++;
        end
      end
      return band;
    endfunction

    function logic [COUNT_BITS-1:0] run_needed(logic [LEVEL_BITS-1:0] lvl);
      logic [COUNT_BITS-1:0] n;
      if (lvl == DRY_LEVEL) n = run_dry;
      else if (lvl >= WET_LEVEL) n = run_wet;
      else n = run_soil;
      return (n == '0) ? 16'd1 : n;
    endfunction

    function void note_sample(bit f, logic [DEFAULT_RAW_BITS-1:0] raw);
      logic [LEVEL_BITS-1:0] cand, prev;
      prev = committed;
      samples++;
      if (f == FUNC_SEED) begin
        seeds++;
        cand = classify(raw, NEUTRAL_LEVEL, '0);
        committed = cand;
        pending_lvl = cand;
        run_count = '0;
      end else begin
        cand = classify(raw, committed, deadband);
        if (cand == committed) begin
          pending_lvl = cand;
          run_count = '0;
        end else if (cand == pending_lvl) begin
          run_count++;
          if (run_count >= run_needed(cand)) begin
            committed = cand;
            run_count = '0;
          end
        end else begin
          pending_lvl = cand;
          run_count = 16'd1;
        end
      end
      if (committed != prev) changes++;
      expected_levels.push_back(committed);
    endfunction

    function void check_level(logic [LEVEL_BITS-1:0] got);
      logic [LEVEL_BITS-1:0] want;
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("level %0d arrived with nothing expected", got);
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("level mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int outstanding();
      return expected_levels.size();
    endfunction
  endclass

  level_tracker tracker = new();

  hysteretic_level_gate_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("watchdog expired with %0d levels outstanding", tracker.outstanding());
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_level(level);
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  function automatic logic [DEFAULT_RAW_BITS-1:0] pinch(int v);
    if (v < 0) return '0;
    if (v > RAW_MAX) return DEFAULT_RAW_BITS'(RAW_MAX);
    return DEFAULT_RAW_BITS'(v);
  endfunction

  // six boundaries, monotonic with random steps, equal neighbors allowed
  function automatic logic [2*CFG_DATA_BITS-1:0] make_ladder(bit falling);
    logic [2*CFG_DATA_BITS-1:0] lad;
    int acc, i;
    acc = int'($urandom_range(0, 200));
    for (i = 0; i < MAX_BOUNDARIES; i++) begin
      lad[i*SLICE_BITS +: SLICE_BITS] = falling ? SLICE_BITS'(RAW_MAX - acc) : SLICE_BITS'(acc);
      acc += int'($urandom_range(0, 640));
    end
    return lad;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    tracker.write_reg(idx, d);
  endtask

  task automatic apply_config(logic [CFG_DATA_BITS-1:0] lo, logic [CFG_DATA_BITS-1:0] hi,
                              int db, bit res, int dry, int soil, int wet);
    write_reg(REG_BOUNDARIES_LOW, lo);
    write_reg(REG_BOUNDARIES_HIGH, hi);
    write_reg(REG_DEADBAND_WIDTH, CFG_DATA_BITS'(db));
    write_reg(REG_SENSOR_RESIST, CFG_DATA_BITS'(res));
    write_reg(REG_CONFIRM_DRY, CFG_DATA_BITS'(dry));
    write_reg(REG_CONFIRM_SOIL, CFG_DATA_BITS'(soil));
    write_reg(REG_CONFIRM_WET, CFG_DATA_BITS'(wet));
    cfg_write <= 1'b0;
    settings++;
  endtask

  task automatic send(bit f, logic [DEFAULT_RAW_BITS-1:0] r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    raw_value <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_sample(f, r);
  endtask

  // hold off input until every committed level has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [2*CFG_DATA_BITS-1:0] lad;
    int p, n, k, len, jit, target;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_UPDATE;
    raw_value = '0;
    cfg_write = 1'b0;
    cfg_index = REG_BOUNDARIES_LOW;
    cfg_data = '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // resistive ladder, odd deadband, mixed confirm runs
    apply_config({12'd1500, 12'd1000, 12'd500}, {12'd3000, 12'd2500, 12'd2000},
                 201, 1'b1, 2, 1, 3);
    send(FUNC_SEED, 12'd0);
    send(FUNC_UPDATE, 12'd4095);
    send(FUNC_UPDATE, 12'd4095);
    send(FUNC_UPDATE, 12'd3050);
    send(FUNC_UPDATE, 12'd4095);
    send(FUNC_UPDATE, 12'd4095);
    send(FUNC_UPDATE, 12'd4095);
    send(FUNC_UPDATE, 12'd2950);
    send(FUNC_UPDATE, 12'd2899);
    send(FUNC_SEED, 12'd2000);
    send(FUNC_SEED, 12'd4095);
    send(FUNC_SEED, 12'd0);
    send(FUNC_UPDATE, 12'd0);
    send(FUNC_UPDATE, 12'd560);
    send(FUNC_UPDATE, 12'd601);
    drain();

    // capacitive, boundaries at the rails, widest deadband, zero and largest confirm counts
    apply_config({12'd3000, 12'd4000, 12'd4095}, {12'd0, 12'd1000, 12'd2000},
                 4095, 1'b0, 0, 65535, 1);
    send(FUNC_SEED, 12'd4095);
    send(FUNC_SEED, 12'd0);
    send(FUNC_SEED, 12'd2500);
    send(FUNC_UPDATE, 12'd0);
    send(FUNC_UPDATE, 12'd4095);
    send(FUNC_SEED, 12'd4095);
    send(FUNC_UPDATE, 12'd0);
    send(FUNC_UPDATE, 12'd0);

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          lad = make_ladder(1'b0);
          apply_config(lad[35:0], lad[71:36], int'($urandom_range(0, 400)), 1'b1,
                       int'($urandom_range(1, 4)), int'($urandom_range(1, 4)),
                       int'($urandom_range(1, 4)));
        end
        1: begin
          lad = make_ladder(1'b1);
          apply_config(lad[35:0], lad[71:36], int'($urandom_range(0, 400)), 1'b0,
                       int'($urandom_range(1, 4)), int'($urandom_range(1, 4)),
                       int'($urandom_range(1, 4)));
        end
        2: begin
          lad = make_ladder(1'b0);
          apply_config(lad[35:0], lad[71:36], 4095, 1'b1, 0,
                       int'($urandom_range(1, 3)), 65535);
        end
        3: begin
          lad = 72'({$urandom, $urandom, $urandom});
          apply_config(lad[35:0], lad[71:36], int'($urandom_range(0, 4095)), 1'b0,
                       int'($urandom_range(0, 3)), int'($urandom_range(0, 3)),
                       int'($urandom_range(0, 3)));
        end
        4: begin
          lad = make_ladder($urandom_range(0, 1) == 1);
          apply_config(lad[35:0], lad[71:36], int'($urandom_range(0, 1000)),
                       $urandom_range(0, 1) == 1, int'($urandom_range(1, 5)),
                       int'($urandom_range(1, 5)), int'($urandom_range(1, 5)));
        end
        default: begin
          calm = 1'b1;
          lad = make_ladder(1'b0);
          apply_config(lad[35:0], lad[71:36], int'($urandom_range(0, 200)), 1'b1,
                       int'($urandom_range(1, 3)), int'($urandom_range(1, 3)),
                       int'($urandom_range(1, 3)));
        end
      endcase

      n = 0;
      while (n < 110) begin
        k = int'($urandom_range(0, 9));
        if (k == 0) begin
          send(FUNC_SEED, pinch(int'($urandom_range(0, RAW_MAX))));
          n++;
        end else if (k == 1) begin
          send($urandom_range(0, 1) == 1, pinch(int'($urandom_range(0, RAW_MAX))));
          n++;
        end else begin
          // runs of near-equal readings, half of them around a boundary, so candidates get confirmed
          if (k < 6)
            target = tracker.boundary(int'($urandom_range(0, 5)))
                     + int'($urandom_range(0, 600)) - 300;
          else
            target = int'($urandom_range(0, RAW_MAX));
          len = int'($urandom_range(1, 7));
          jit = int'($urandom_range(0, 30));
          repeat (len) begin
            send(FUNC_UPDATE, pinch(target + int'($urandom_range(0, 2 * jit)) - jit));
            n++;
          end
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("%0d samples (%0d seeds) under %0d register settings", tracker.samples,
             tracker.seeds, settings);
    $display("%0d committed level changes, %0d failures", tracker.changes, tracker.errors);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== hysteretic_level_gate_core.f =====
rtl/core/hlg_pkg.sv
rtl/core/hlg_classify.sv
rtl/core/hlg_track.sv
rtl/core/hysteretic_level_gate_core.sv
verif/hysteretic_level_gate_core_test.sv
